### design/cvr_pkg.sv
// Package for the contact velocity response core: shared widths and constants.
// No dependencies.
`default_nettype none
package cvr_pkg;
    localparam int unsigned AxW  = 16;
    localparam int unsigned VelW = 16;
    localparam int unsigned ThrW = 15;
    localparam logic [ThrW-1:0] ThrReset = 15'd11585;
    localparam int unsigned InTdataW  = 200; // 193 bits of fields, padded to bytes
    localparam int unsigned OutTdataW = 144;
    localparam int unsigned OutTuserW = 2;
endpackage
`default_nettype wire

### design/contact_velocity_response_core.sv
// Contact velocity response core: push-out, restitution and friction per contact.
// Depends on cvr_pkg.
// The result passes through five register stages, stage 1 to stage 5.
// Throughput: one contact per cycle; set by the five-stage multiply pipeline,
// which advances as a whole whenever the output register is free or being taken.
// Reset: synchronous active-low clears all stage valid bits and loads the
// grounded threshold with 11585.
`default_nettype none
module contact_velocity_response_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // axis_x, axis_y, axis_z, depth, vel_a_x/y/z, vel_b_x/y/z, material_a, material_b
    input  wire logic [cvr_pkg::InTdataW-1:0]    s_axis_tdata,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cvr_pkg::ThrW-1:0]        i_cfg_data,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // push_x/y/z, new_vel_a_x/y/z, new_vel_b_x/y/z
    output logic [cvr_pkg::OutTdataW-1:0]        m_axis_tdata,
    // grounded, b_changed
    output logic [cvr_pkg::OutTuserW-1:0]        m_axis_tuser
);
    import cvr_pkg::*;

    logic [ThrW-1:0] r_thr;
    logic [4:0]      r_vld;
    logic            w_adv;

    assign w_adv         = !r_vld[4] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_vld[4];

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrReset;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // Valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], s_axis_tvalid};
        end
    end

    // Stage 1: unpack and register
    logic signed [15:0] r1_ax [3];
    logic signed [15:0] r1_va [3];
    logic signed [15:0] r1_vb [3];
    logic [15:0] r1_dep;
    logic [7:0]  r1_ea, r1_fa, r1_eb, r1_fb;
    logic        r1_st, r1_gnd;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_ax[i] <= s_axis_tdata[16*i +: 16];
                r1_va[i] <= s_axis_tdata[64+16*i +: 16];
                r1_vb[i] <= s_axis_tdata[112+16*i +: 16];
            end
            r1_dep <= s_axis_tdata[48 +: 16];
            r1_fa  <= s_axis_tdata[160 +: 8];
            r1_ea  <= s_axis_tdata[168 +: 8];
            r1_fb  <= s_axis_tdata[176 +: 8];
            r1_eb  <= s_axis_tdata[184 +: 8];
            r1_st  <= s_axis_tdata[192];
            r1_gnd <= (-$signed({{2{s_axis_tdata[47]}}, s_axis_tdata[32 +: 16]}))
                      > $signed({3'b000, r_thr});
        end
    end

    // Stage 2: dot product terms and push products
    logic signed [31:0] r2_pa [3];
    logic signed [31:0] r2_pb [3];
    logic signed [33:0] r2_push [3];
    logic signed [15:0] r2_ax [3];
    logic signed [15:0] r2_va [3];
    logic signed [15:0] r2_vb [3];
    logic [7:0]  r2_ea, r2_fa, r2_eb, r2_fb;
    logic        r2_st, r2_gnd;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_pa[i]   <= r1_va[i] * r1_ax[i];
                r2_pb[i]   <= r1_vb[i] * r1_ax[i];
                r2_push[i] <= -(34'(r1_ax[i]) * $signed({18'd0, r1_dep}));
            end
            r2_ax <= r1_ax; r2_va <= r1_va; r2_vb <= r1_vb;
            r2_ea <= r1_ea; r2_fa <= r1_fa; r2_eb <= r1_eb; r2_fb <= r1_fb;
            r2_st <= r1_st; r2_gnd <= r1_gnd;
        end
    end

    // Stage 3: sum dots, pick scale factors, round push
    logic signed [33:0] w_da, w_db;
    logic [7:0]         w_emin;
    assign w_da   = 34'(r2_pa[0]) + 34'(r2_pa[1]) + 34'(r2_pa[2]);
    assign w_db   = 34'(r2_pb[0]) + 34'(r2_pb[1]) + 34'(r2_pb[2]);
    assign w_emin = (r2_ea < r2_eb) ? r2_ea : r2_eb;

    function automatic logic [15:0] sat_rnd(input logic signed [63:0] v, input int unsigned s);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (t > 64'sd32767) return 16'h7FFF;
        if (t < -64'sd32768) return 16'h8000;
        return t[15:0];
    endfunction

    logic signed [33:0] r3_da, r3_db;
    logic signed [9:0]  r3_nsa, r3_nsb;
    logic [8:0]         r3_tsa, r3_tsb;
    logic               r3_cha, r3_chb;
    logic [15:0]        r3_push [3];
    logic signed [15:0] r3_ax [3];
    logic signed [15:0] r3_va [3];
    logic signed [15:0] r3_vb [3];
    logic               r3_gnd;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_da <= w_da;
            r3_db <= w_db;
            r3_tsa <= 9'd256 - {1'b0, r2_fa};
            r3_tsb <= 9'd256 - {1'b0, r2_fb};
            if (r2_st) begin
                r3_cha <= 1'b1;
                r3_nsa <= (w_da > 0) ? -$signed({2'b00, r2_ea}) : 10'sd256;
                r3_chb <= 1'b0;
            end else begin
                r3_cha <= w_da > 0;
                r3_nsa <= -$signed({2'b00, w_emin});
                r3_chb <= w_db < 0;
            end
            r3_nsb <= -$signed({2'b00, w_emin});
            for (int i = 0; i < 3; i++) r3_push[i] <= sat_rnd(64'(r2_push[i]), 14);
            r3_ax <= r2_ax; r3_va <= r2_va; r3_vb <= r2_vb; r3_gnd <= r2_gnd;
        end
    end

    // Stage 4: normal parts (Q.28) and tangent parts
    logic signed [50:0] r4_na [3];
    logic signed [50:0] r4_nb [3];
    logic signed [50:0] r4_ta [3];
    logic signed [50:0] r4_tb [3];
    logic signed [9:0]  r4_nsa, r4_nsb;
    logic [8:0]         r4_tsa, r4_tsb;
    logic               r4_cha, r4_chb, r4_gnd;
    logic [15:0]        r4_push [3];
    logic signed [15:0] r4_va [3];
    logic signed [15:0] r4_vb [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r4_na[i] <= 51'(r3_ax[i]) * 51'(r3_da);
                r4_nb[i] <= 51'(r3_ax[i]) * 51'(r3_db);
                r4_ta[i] <= (51'(r3_va[i]) <<< 28) - 51'(r3_ax[i]) * 51'(r3_da);
                r4_tb[i] <= (51'(r3_vb[i]) <<< 28) - 51'(r3_ax[i]) * 51'(r3_db);
            end
            r4_nsa <= r3_nsa; r4_nsb <= r3_nsb; r4_tsa <= r3_tsa; r4_tsb <= r3_tsb;
            r4_cha <= r3_cha; r4_chb <= r3_chb; r4_gnd <= r3_gnd;
            r4_push <= r3_push; r4_va <= r3_va; r4_vb <= r3_vb;
        end
    end

    // Stage 5: scale, round, saturate, hold result
    logic [15:0] r5_a [3];
    logic [15:0] r5_b [3];
    logic [15:0] r5_push [3];
    logic        r5_gnd, r5_chb;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r5_a[i] <= r4_cha
                    ? sat_rnd(64'(r4_na[i]) * 64'(r4_nsa)
                              + 64'(r4_ta[i]) * $signed({55'd0, r4_tsa}), 36)
                    : r4_va[i];
                r5_b[i] <= r4_chb
                    ? sat_rnd(64'(r4_nb[i]) * 64'(r4_nsb)
                              + 64'(r4_tb[i]) * $signed({55'd0, r4_tsb}), 36)
                    : r4_vb[i];
            end
            r5_push <= r4_push; r5_gnd <= r4_gnd; r5_chb <= r4_chb;
        end
    end

    assign m_axis_tdata = {r5_b[2], r5_b[1], r5_b[0], r5_a[2], r5_a[1], r5_a[0],
                           r5_push[2], r5_push[1], r5_push[0]};
    assign m_axis_tuser = {r5_chb, r5_gnd};
endmodule
`default_nettype wire
